// ===== hw/rtl/uff_pkg.sv =====
package uff_pkg;

   localparam int FILL_W = 8;

   localparam logic [2:0] OP_PUSH    = 3'd0;
   localparam logic [2:0] OP_POP     = 3'd1;
   localparam logic [2:0] OP_TX_TAKE = 3'd2;
   localparam logic [2:0] OP_RX_BYTE = 3'd3;
   localparam logic [2:0] OP_TX_DONE = 3'd4;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] data_byte;
      logic       frame_start;
      logic       ninth_bit;
      logic       keep_receiving;
   } req_type;

   typedef struct packed {
      logic              accepted;
      logic [7:0]        data_out;
      logic              ninth_bit_out;
      logic              rx_became_nonempty;
      logic              tx_became_empty;
      logic              tx_all_sent;
      logic              skipping;
      logic [FILL_W-1:0] tx_fill;
      logic [FILL_W-1:0] rx_fill;
   } rsp_type;

   typedef struct packed {
      logic accepted;
      logic became_empty;
      logic all_sent;
      logic took;
   } tx_flags_type;

   typedef struct packed {
      logic accepted;
      logic became_nonempty;
      logic popped;
   } rx_flags_type;

endpackage

// ===== hw/rtl/uff_tx_queue.sv =====
module uff_tx_queue #(
   parameter int DEPTH = 128
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   input  uff_pkg::req_type          cmd,
   output uff_pkg::tx_flags_type     flags,
   output logic [7:0]                rd_byte,
   output logic                      rd_mark,
   output logic [uff_pkg::FILL_W-1:0] fill
);
   import uff_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam logic [FILL_W-1:0] DEPTH_C = FILL_W'(DEPTH);
   localparam logic [FILL_W:0]   DEPTH_W = (FILL_W + 1)'(DEPTH);
   localparam logic [PW-1:0]     LAST    = PW'(DEPTH - 1);

   logic [8:0]        mem [DEPTH];
   logic [8:0]        rd_ff;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] count_ff, count_in;
   logic [FILL_W:0]   wr_sum;
   logic [PW-1:0]     wr_idx;
   logic              do_push, do_take;

   always_comb begin
      do_push = cmd_valid && cmd.operation == OP_PUSH && count_ff != DEPTH_C;
      do_take = cmd_valid && cmd.operation == OP_TX_TAKE && count_ff != '0;
      wr_sum  = (FILL_W + 1)'(rd_ptr_ff) + (FILL_W + 1)'(count_ff);
      wr_idx  = (wr_sum >= DEPTH_W) ? PW'(wr_sum - DEPTH_W) : PW'(wr_sum);
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         count_in = count_ff + 1'b1;
      end
      if (do_take) begin
         count_in  = count_ff - 1'b1;
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      flags.accepted     = do_push || do_take;
      flags.became_empty = do_take && count_ff == FILL_W'(1);
      flags.all_sent     = cmd_valid && cmd.operation == OP_TX_DONE && count_ff == '0;
      flags.took         = do_take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_idx] <= {cmd.frame_start, cmd.data_byte};
      end
      rd_ff <= mem[rd_ptr_ff];
   end

   assign rd_byte = rd_ff[7:0];
   assign rd_mark = rd_ff[8];
   assign fill    = count_ff;

endmodule

// ===== hw/rtl/uff_rx_queue.sv =====
module uff_rx_queue #(
   parameter int DEPTH = 128
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      mode,
   input  logic                      csr_wr_en,
   input  logic                      csr_wr_data,
   input  logic                      cmd_valid,
   input  uff_pkg::req_type          cmd,
   output uff_pkg::rx_flags_type     flags,
   output logic [7:0]                rd_byte,
   output logic                      skipping,
   output logic [uff_pkg::FILL_W-1:0] fill
);
   import uff_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam logic [FILL_W-1:0] DEPTH_C = FILL_W'(DEPTH);
   localparam logic [FILL_W:0]   DEPTH_W = (FILL_W + 1)'(DEPTH);
   localparam logic [PW-1:0]     LAST    = PW'(DEPTH - 1);

   logic [7:0]        mem [DEPTH];
   logic [7:0]        rd_ff;
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [FILL_W-1:0] count_ff, count_in;
   logic              skip_ff, skip_in;
   logic [FILL_W:0]   rd_diff;
   logic [PW-1:0]     rd_idx;
   logic              rx_byte, pass, do_store, do_pop;

   always_comb begin
      rx_byte = cmd_valid && cmd.operation == OP_RX_BYTE;
      do_pop  = cmd_valid && cmd.operation == OP_POP && count_ff != '0;
      pass    = 1'b1;
      skip_in = skip_ff;
      if (rx_byte && mode) begin
         if (skip_ff && !cmd.ninth_bit) begin
            pass = 1'b0;
         end else begin
            skip_in = !cmd.keep_receiving;
         end
      end
      if (csr_wr_en) begin
         skip_in = csr_wr_data;
      end
      do_store = rx_byte && pass && count_ff != DEPTH_C;
      // oldest entry sits count places behind the write pointer
      rd_diff = (FILL_W + 1)'(wr_ptr_ff) - (FILL_W + 1)'(count_ff);
      rd_idx  = rd_diff[FILL_W] ? PW'(rd_diff + DEPTH_W) : PW'(rd_diff);
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (do_store) begin
         count_in  = count_ff + 1'b1;
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         count_in = count_ff - 1'b1;
      end
      flags.accepted        = do_store || do_pop;
      flags.became_nonempty = do_store && count_ff == '0;
      flags.popped          = do_pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         count_ff  <= '0;
         skip_ff   <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
         skip_ff   <= skip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_store) begin
         mem[wr_ptr_ff] <= cmd.data_byte;
      end
      rd_ff <= mem[rd_idx];
   end

   assign rd_byte  = rd_ff;
   assign skipping = skip_ff;
   assign fill     = count_ff;

endmodule

// ===== hw/rtl/uart_fifo_multiprocessor_filter.sv =====
// Channel   Ports                          Handshake
// request   start, busy, req_data          beat taken when start && !busy
// response  rsp_valid, rsp_data            one-cycle strobe, no backpressure
// config    csr_wr_en, csr_wr_data         written when csr_wr_en
//
// One beat per cycle; busy is always low. A beat is registered at its
// accepting edge, updates the buffers and counters at the next edge, where
// the buffer read data and flags are also registered, and its response is
// shown in the cycle after that. Synchronous reset empties both buffers
// and clears the mode and skip state.
module uart_fifo_multiprocessor_filter #(
   parameter int TX_DEPTH = 128,
   parameter int RX_DEPTH = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  uff_pkg::req_type  req_data,
   output logic              rsp_valid,
   output uff_pkg::rsp_type  rsp_data,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);
   import uff_pkg::*;

   req_type           req_ff;
   logic              req_valid_ff;
   logic              rsp_valid_ff;
   logic              mode_ff;
   tx_flags_type      tx_flags, tx_flags_ff;
   rx_flags_type      rx_flags, rx_flags_ff;
   logic              mark_en_ff;
   logic [7:0]        tx_byte, rx_byte;
   logic              tx_mark, rx_skip;
   logic [FILL_W-1:0] tx_fill, rx_fill;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
         rsp_valid_ff <= req_valid_ff;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
      tx_flags_ff <= tx_flags;
      rx_flags_ff <= rx_flags;
      mark_en_ff  <= mode_ff;
   end

   uff_tx_queue #(.DEPTH(TX_DEPTH)) u_tx (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (req_valid_ff),
      .cmd       (req_ff),
      .flags     (tx_flags),
      .rd_byte   (tx_byte),
      .rd_mark   (tx_mark),
      .fill      (tx_fill)
   );

   uff_rx_queue #(.DEPTH(RX_DEPTH)) u_rx (
      .clock       (clock),
      .reset       (reset),
      .mode        (mode_ff),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd_valid   (req_valid_ff),
      .cmd         (req_ff),
      .flags       (rx_flags),
      .rd_byte     (rx_byte),
      .skipping    (rx_skip),
      .fill        (rx_fill)
   );

   always_comb begin
      rsp_data.accepted           = tx_flags_ff.accepted || rx_flags_ff.accepted;
      rsp_data.data_out           = tx_flags_ff.took   ? tx_byte :
                                    rx_flags_ff.popped ? rx_byte : 8'd0;
      rsp_data.ninth_bit_out      = tx_flags_ff.took && mark_en_ff && tx_mark;
      rsp_data.rx_became_nonempty = rx_flags_ff.became_nonempty;
      rsp_data.tx_became_empty    = tx_flags_ff.became_empty;
      rsp_data.tx_all_sent        = tx_flags_ff.all_sent;
      rsp_data.skipping           = rx_skip;
      rsp_data.tx_fill            = tx_fill;
      rsp_data.rx_fill            = rx_fill;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== verif/uart_fifo_filter_checker.sv =====
module uart_fifo_filter_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  uff_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  uff_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data,
   output int               fail_count,
   output int               outstanding
);
   import uff_pkg::*;

   localparam int TX_SLOTS = 128;
   localparam int RX_SLOTS = 128;
   localparam int REPORT_LIMIT = 10;

   logic [7:0] tx_bytes [0:TX_SLOTS-1];
   logic       tx_frame_mark [0:TX_SLOTS-1];
   logic [6:0] tx_head;
   logic [7:0] tx_level;
   logic [7:0] rx_bytes [0:RX_SLOTS-1];
   logic [6:0] rx_tail;
   logic [7:0] rx_level;
   logic       skip_armed;
   logic       mp_mode;

   rsp_type    pending_rsp [$];

   initial begin
      fail_count = 0;
      outstanding = 0;
   end

   task automatic step_buffers(input req_type r, output rsp_type o);
      logic [6:0] slot;
      logic       passed;
      o = '0;
      passed = 1'b1;
      case (r.operation)
         OP_PUSH: begin
            if (tx_level < TX_SLOTS) begin
               slot = tx_head + tx_level[6:0];
               tx_bytes[slot] = r.data_byte;
               tx_frame_mark[slot] = r.frame_start;
               tx_level = tx_level + 8'd1;
               o.accepted = 1'b1;
            end
         end
         OP_POP: begin
            if (rx_level != 0) begin
               slot = rx_tail - rx_level[6:0];
               o.data_out = rx_bytes[slot];
               rx_level = rx_level - 8'd1;
               o.accepted = 1'b1;
            end
         end
         OP_TX_TAKE: begin
            if (tx_level != 0) begin
               o.data_out = tx_bytes[tx_head];
               o.ninth_bit_out = mp_mode & tx_frame_mark[tx_head];
               tx_head = tx_head + 7'd1;
               tx_level = tx_level - 8'd1;
               o.tx_became_empty = (tx_level == 0);
               o.accepted = 1'b1;
            end
         end
         OP_RX_BYTE: begin
            if (mp_mode) begin
               if (skip_armed && !r.ninth_bit) begin
                  passed = 1'b0;
               end else begin
                  skip_armed = !r.keep_receiving;
               end
            end
            if (passed && rx_level < RX_SLOTS) begin
               rx_bytes[rx_tail] = r.data_byte;
               rx_tail = rx_tail + 7'd1;
               rx_level = rx_level + 8'd1;
               o.rx_became_nonempty = (rx_level == 1);
               o.accepted = 1'b1;
            end
         end
         OP_TX_DONE: begin
            o.tx_all_sent = (tx_level == 0);
         end
         default: begin
         end
      endcase
      o.skipping = skip_armed;
      o.tx_fill = tx_level;
      o.rx_fill = rx_level;
   endtask

   function automatic string show(rsp_type r);
      return $sformatf({"acc=%0b data=%02h n9=%0b rxne=%0b txe=%0b sent=%0b",
                        " skip=%0b txf=%0d rxf=%0d"},
                       r.accepted, r.data_out, r.ninth_bit_out, r.rx_became_nonempty,
                       r.tx_became_empty, r.tx_all_sent, r.skipping, r.tx_fill, r.rx_fill);
   endfunction

   task automatic log_miss(string what);
      if (fail_count < REPORT_LIMIT) begin
         $display("%0t: %s", $time, what);
      end
      fail_count = fail_count + 1;
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type got;
      if (reset) begin
         tx_head = '0;
         tx_level = '0;
         rx_tail = '0;
         rx_level = '0;
         skip_armed = 1'b0;
         mp_mode = 1'b0;
         pending_rsp.delete();
      end else begin
         if (rsp_valid) begin
            got = rsp_data;
            if (pending_rsp.size() == 0) begin
               log_miss({"response beat with none expected: ", show(got)});
            end else begin
               want = pending_rsp.pop_front();
               if (got.accepted !== want.accepted ||
                   got.data_out !== want.data_out ||
                   got.ninth_bit_out !== want.ninth_bit_out ||
                   got.rx_became_nonempty !== want.rx_became_nonempty ||
                   got.tx_became_empty !== want.tx_became_empty ||
                   got.tx_all_sent !== want.tx_all_sent ||
                   got.skipping !== want.skipping ||
                   got.tx_fill !== want.tx_fill ||
                   got.rx_fill !== want.rx_fill) begin
                  log_miss({"expected ", show(want), " got ", show(got)});
               end
            end
         end
         if (csr_wr_en) begin
            mp_mode = csr_wr_data;
            skip_armed = csr_wr_data;
         end
         if (start && !busy) begin
            step_buffers(req_data, want);
            pending_rsp.push_back(want);
         end
      end
      outstanding = pending_rsp.size();
   end

endmodule

// ===== verif/tb_uart_fifo_multiprocessor_filter.sv =====
module tb_uart_fifo_multiprocessor_filter;
   import uff_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SEG_MIXED = 0;
   localparam int SEG_TX_FLOOD = 1;
   localparam int SEG_RX_FLOOD = 2;
   localparam int SEG_DRAIN = 3;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_wr_en;
   logic    csr_wr_data;
   int      fail_count;
   int      outstanding;

   int      cycle_count = 0;
   bit      gaps_on;
   bit      cur_mode;
   int      frame_left;
   bit      addr_kept;
   int      random_sent;
   int      seg_kind;
   int      seg_len;
   req_type beat;

   uart_fifo_multiprocessor_filter dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   uart_fifo_filter_checker checker_0 (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("uart_fifo_multiprocessor_filter: mismatch");
         $finish;
      end
   end

   function automatic req_type pack_req(logic [2:0] op, logic [7:0] d, logic fs, logic nb,
                                        logic kr);
      req_type r;
      r.operation = op;
      r.data_byte = d;
      r.frame_start = fs;
      r.ninth_bit = nb;
      r.keep_receiving = kr;
      return r;
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_beat(input req_type r);
      while (gaps_on && $urandom_range(0, 99) < 36) begin
         start <= 1'b0;
         @(posedge clock);
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_mode(input bit m);
      start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cur_mode = m;
      frame_left = 0;
   endtask

   // rx byte: in multiprocessor mode mostly well-formed frames, address first
   task automatic make_rx(output req_type r);
      r = pack_req(OP_RX_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      if (cur_mode && $urandom_range(0, 99) >= 15) begin
         if (frame_left == 0) begin
            frame_left = $urandom_range(1, 8);
            addr_kept = ($urandom_range(0, 3) != 0);
            r.ninth_bit = 1'b1;
            r.keep_receiving = addr_kept;
         end else begin
            frame_left = frame_left - 1;
            r.ninth_bit = 1'b0;
            r.keep_receiving = (frame_left != 0);
         end
      end
   endtask

   task automatic make_beat(input int kind, output req_type r);
      int roll;
      int t_push;
      int t_pop;
      int t_take;
      int t_rx;
      int t_done;
      case (kind)
         SEG_TX_FLOOD: begin
            t_push = 88; t_pop = 90; t_take = 94; t_rx = 97; t_done = 99;
         end
         SEG_RX_FLOOD: begin
            t_push = 3; t_pop = 8; t_take = 10; t_rx = 97; t_done = 99;
         end
         SEG_DRAIN: begin
            t_push = 3; t_pop = 48; t_take = 93; t_rx = 96; t_done = 99;
         end
         default: begin
            t_push = 22; t_pop = 44; t_take = 66; t_rx = 88; t_done = 96;
         end
      endcase
      roll = $urandom_range(0, 99);
      r = pack_req(3'($urandom_range(5, 7)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      if (roll < t_push) begin
         r.operation = OP_PUSH;
      end else if (roll < t_pop) begin
         r.operation = OP_POP;
      end else if (roll < t_take) begin
         r.operation = OP_TX_TAKE;
      end else if (roll < t_rx) begin
         make_rx(r);
      end else if (roll < t_done) begin
         r.operation = OP_TX_DONE;
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      gaps_on = 1'b1;
      cur_mode = 1'b0;
      frame_left = 0;
      addr_kept = 1'b0;
      random_sent = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_mode(1'b0);
      send_beat(pack_req(OP_POP, 8'h00, 1'b0, 1'b0, 1'b0));
      send_beat(pack_req(OP_TX_TAKE, 8'h00, 1'b0, 1'b0, 1'b0));
      send_beat(pack_req(OP_TX_DONE, 8'h00, 1'b0, 1'b0, 1'b0));
      send_beat(pack_req(OP_PUSH, 8'h00, 1'b0, 1'b0, 1'b0));
      send_beat(pack_req(OP_PUSH, 8'hFF, 1'b1, 1'b1, 1'b1));
      send_beat(pack_req(OP_TX_DONE, 8'hFF, 1'b1, 1'b1, 1'b1));
      send_beat(pack_req(OP_TX_TAKE, 8'h00, 1'b0, 1'b0, 1'b0));
      send_beat(pack_req(OP_TX_TAKE, 8'h00, 1'b0, 1'b0, 1'b0));
      send_beat(pack_req(OP_RX_BYTE, 8'h00, 1'b0, 1'b1, 1'b0));
      send_beat(pack_req(OP_RX_BYTE, 8'hFF, 1'b1, 1'b0, 1'b1));
      send_beat(pack_req(OP_POP, 8'h00, 1'b0, 1'b0, 1'b0));
      send_beat(pack_req(OP_POP, 8'h00, 1'b0, 1'b0, 1'b0));
      send_beat(pack_req(OP_POP, 8'h00, 1'b0, 1'b0, 1'b0));
      send_beat(pack_req(3'd5, 8'h5A, 1'b0, 1'b1, 1'b0));
      send_beat(pack_req(3'd7, 8'hFF, 1'b1, 1'b1, 1'b1));

      // multiprocessor mode: skip, address, data, re-arm, discard
      set_mode(1'b1);
      send_beat(pack_req(OP_RX_BYTE, 8'h3C, 1'b0, 1'b0, 1'b1));
      send_beat(pack_req(OP_RX_BYTE, 8'h81, 1'b0, 1'b1, 1'b1));
      send_beat(pack_req(OP_RX_BYTE, 8'h7E, 1'b0, 1'b0, 1'b1));
      send_beat(pack_req(OP_RX_BYTE, 8'h42, 1'b0, 1'b0, 1'b0));
      send_beat(pack_req(OP_RX_BYTE, 8'h99, 1'b0, 1'b0, 1'b1));
      send_beat(pack_req(OP_PUSH, 8'hA5, 1'b1, 1'b0, 1'b0));
      send_beat(pack_req(OP_TX_TAKE, 8'h00, 1'b0, 1'b0, 1'b0));
      send_beat(pack_req(OP_POP, 8'h00, 1'b0, 1'b0, 1'b0));
      send_beat(pack_req(OP_POP, 8'h00, 1'b0, 1'b0, 1'b0));
      send_beat(pack_req(OP_POP, 8'h00, 1'b0, 1'b0, 1'b0));

      for (int ph = 0; ph < 3; ph++) begin
         set_mode(ph != 1);
         for (int sg = 0; sg < 4; sg++) begin
            case (sg)
               0: begin seg_kind = SEG_MIXED; seg_len = 60; end
               1: begin seg_kind = SEG_TX_FLOOD; seg_len = 150; end
               2: begin seg_kind = SEG_RX_FLOOD; seg_len = 170; end
               default: begin seg_kind = SEG_DRAIN; seg_len = 270; end
            endcase
            for (int k = 0; k < seg_len; k++) begin
               gaps_on = !(random_sent >= 700 && random_sent < 1000);
               make_beat(seg_kind, beat);
               send_beat(beat);
               random_sent = random_sent + 1;
            end
         end
      end

      start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (6) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("uart_fifo_multiprocessor_filter: match");
      end else begin
         $display("uart_fifo_multiprocessor_filter: mismatch");
      end
      $finish;
   end

endmodule

// ===== uart_fifo_multiprocessor_filter.f =====
hw/rtl/uff_pkg.sv
hw/rtl/uff_tx_queue.sv
hw/rtl/uff_rx_queue.sv
hw/rtl/uart_fifo_multiprocessor_filter.sv
verif/uart_fifo_filter_checker.sv
verif/tb_uart_fifo_multiprocessor_filter.sv
